FILE: sv/tvsl_pkg.sv
package tvsl_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int DIM_W      = 7;
   localparam int ZDIM_W     = 5;
   localparam int SCORE_W    = 60;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SIZE        = 3'd0,
      CSR_Y_SIZE        = 3'd1,
      CSR_Z_SIZE        = 3'd2,
      CSR_COLUMN_SELECT = 3'd3,
      CSR_ROW_SELECT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_NO_FUNC  = 2'd1,
      ERR_TOO_MANY = 2'd2,
      ERR_PARTIAL  = 2'd3
   } err_code_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       functional;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic               spike_found;
      logic [DIM_W-1:0]   peak_x;
      logic [DIM_W-1:0]   peak_y;
      logic [SCORE_W-1:0] peak_score;
      logic [SCORE_W-1:0] second_score;
      err_code_type       error_code;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]  x_size;
      logic [DIM_W-1:0]  y_size;
      logic [ZDIM_W-1:0] z_size;
      logic [DIM_W-1:0]  column_select;
      logic [DIM_W-1:0]  row_select;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIM1,
      ST_DIM2,
      ST_READ,
      ST_UPDATE,
      ST_CHECK,
      ST_SC_INIT,
      ST_SC_READ,
      ST_SC_MUL,
      ST_SC_ACC,
      ST_SC_COL,
      ST_REPORT
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic dims1;
      logic dims2;
      logic rd;
      logic upd;
      logic sc_init;
      logic sc_rd;
      logic sc_mul;
      logic sc_acc;
      logic sc_col;
      logic report;
      logic clr_step;
   } dp_cmd_type;

   typedef struct packed {
      logic         last;
      err_code_type err;
      logic         z_last;
      logic         col_last;
      logic         clr_last;
   } dp_status_type;

endpackage

FILE: sv/tvsl_ctrl.sv
module tvsl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tvsl_pkg::dp_status_type status,
   output tvsl_pkg::dp_cmd_type    cmd
);
   import tvsl_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DIM1;
            end
         end
         ST_DIM1: begin
            cmd.dims1 = 1'b1;
            state_in  = ST_DIM2;
         end
         ST_DIM2: begin
            cmd.dims2 = 1'b1;
            state_in  = ST_READ;
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd  = 1'b1;
            state_in = status.last ? ST_CHECK : ST_IDLE;
         end
         ST_CHECK: begin
            state_in = (status.err != ERR_NONE) ? ST_REPORT : ST_SC_INIT;
         end
         ST_SC_INIT: begin
            cmd.sc_init = 1'b1;
            state_in    = ST_SC_READ;
         end
         ST_SC_READ: begin
            cmd.sc_rd = 1'b1;
            state_in  = ST_SC_MUL;
         end
         ST_SC_MUL: begin
            cmd.sc_mul = 1'b1;
            state_in   = ST_SC_ACC;
         end
         ST_SC_ACC: begin
            cmd.sc_acc = 1'b1;
            state_in   = status.z_last ? ST_SC_COL : ST_SC_READ;
         end
         ST_SC_COL: begin
            cmd.sc_col = 1'b1;
            state_in   = status.col_last ? ST_REPORT : ST_SC_READ;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

FILE: sv/tvsl_dp.sv
module tvsl_dp #(
   parameter int MAX_X      = 64,
   parameter int MAX_Y      = 64,
   parameter int MAX_Z      = 16,
   parameter int MAX_FRAMES = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tvsl_pkg::cfg_type       cfg,
   input  tvsl_pkg::req_type       req_data,
   input  tvsl_pkg::dp_cmd_type    cmd,
   output tvsl_pkg::dp_status_type status,
   output tvsl_pkg::rsp_type       rsp_data
);
   import tvsl_pkg::*;

   localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
   localparam int AW    = $clog2(DEPTH);
   localparam int VDW   = $clog2(DEPTH + 1);
   localparam int SDW   = $clog2(MAX_X * MAX_Y + 1);
   localparam int XW    = $clog2(MAX_X + 1);
   localparam int YW    = $clog2(MAX_Y + 1);
   localparam int ZW    = $clog2(MAX_Z + 1);
   localparam int FCW   = $clog2(MAX_FRAMES + 1);
   localparam int FRW   = $clog2(MAX_FRAMES + 2);
   localparam int LW    = $clog2(MAX_FRAMES);
   localparam int SW    = SAMPLE_W + LW;
   localparam int QW    = 2 * SAMPLE_W - 1 + LW;
   localparam int DW    = 2 * SW;

   // clamped sizes
   logic [XW-1:0] xs;
   logic [YW-1:0] ys;
   logic [ZW-1:0] zs;

   always_comb begin
      if (cfg.x_size == '0) xs = XW'(1);
      else if (32'(cfg.x_size) > MAX_X) xs = XW'(MAX_X);
      else xs = XW'(cfg.x_size);
      if (cfg.y_size == '0) ys = YW'(1);
      else if (32'(cfg.y_size) > MAX_Y) ys = YW'(MAX_Y);
      else ys = YW'(cfg.y_size);
      if (cfg.z_size == '0) zs = ZW'(1);
      else if (32'(cfg.z_size) > MAX_Z) zs = ZW'(MAX_Z);
      else zs = ZW'(cfg.z_size);
   end

   logic signed [SW-1:0] sum_mem [DEPTH];
   logic [QW-1:0]        sq_mem [DEPTH];

   logic signed [SAMPLE_W-1:0] smp_ff;
   logic                       func_ff;
   logic                       last_ff;
   logic [2*SAMPLE_W-2:0]      sqr_ff;
   logic [SDW-1:0]             sdim_ff;
   logic [VDW-1:0]             vdim_ff;
   logic [AW-1:0]              addr_ff;
   logic signed [SW-1:0]       rd_sum_ff;
   logic [QW-1:0]              rd_sq_ff;
   logic [DW-1:0]              a_ff;
   logic [DW-1:0]              b_ff;
   logic [SCORE_W-1:0]         col_ff;
   logic [SCORE_W-1:0]         best_ff;
   logic [SCORE_W-1:0]         second_ff;
   logic                       has_second_ff;
   logic                       first_ff;
   logic [XW-1:0]              bx_ff;
   logic [YW-1:0]              by_ff;
   logic [XW-1:0]              x_ff;
   logic [YW-1:0]              y_ff;
   logic [ZW-1:0]              z_ff;
   logic [AW-1:0]              k_ff;
   logic [AW-1:0]              cbase_ff;

   // control state
   logic [AW-1:0]  pos_ff;
   logic [FCW-1:0] fc_ff;
   logic [FRW-1:0] frc_ff;
   logic [AW-1:0]  clr_addr_ff;

   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic                 mem_we;
   logic signed [SW-1:0] wsum;
   logic [QW-1:0]        wsq;
   logic                 acc_ok;
   logic                 frame_end;
   logic signed [31:0]   prod;
   logic [SW-1:0]        mag;
   logic [DW-1:0]        diff;
   logic [SCORE_W:0]     col_sum;
   logic [SCORE_W-1:0]   col_masked;
   logic                 spike;

   always_comb begin
      rd_addr   = (VDW'(pos_ff) >= vdim_ff) ? AW'(vdim_ff - VDW'(1)) : pos_ff;
      raddr     = cmd.sc_rd ? k_ff : rd_addr;
      acc_ok    = func_ff && (frc_ff < FRW'(MAX_FRAMES));
      frame_end = (VDW'(addr_ff) + VDW'(1)) >= vdim_ff;
      mem_we    = cmd.clr_step || (cmd.upd && acc_ok);
      waddr     = cmd.clr_step ? clr_addr_ff : addr_ff;
      wsum      = cmd.clr_step ? '0 : rd_sum_ff + SW'(smp_ff);
      wsq       = cmd.clr_step ? '0 : rd_sq_ff + QW'(sqr_ff);
      prod      = 32'(smp_ff) * 32'(smp_ff);
      mag       = unsigned'(rd_sum_ff[SW-1] ? -rd_sum_ff : rd_sum_ff);
      diff      = (a_ff > b_ff) ? a_ff - b_ff : '0;
      col_sum   = {1'b0, col_ff} + (SCORE_W + 1)'(diff);
      col_masked = col_ff;
      if (cfg.column_select != '0 && (32'(x_ff) + 1) != 32'(cfg.column_select))
         col_masked = '0;
      if (cfg.row_select != '0 && (32'(y_ff) + 1) != 32'(cfg.row_select))
         col_masked = '0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[waddr] <= wsum;
         sq_mem[waddr]  <= wsq;
      end
      rd_sum_ff <= sum_mem[raddr];
      rd_sq_ff  <= sq_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         fc_ff       <= '0;
         frc_ff      <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.upd) begin
            if (frame_end) begin
               pos_ff <= '0;
               if (frc_ff < FRW'(MAX_FRAMES)) begin
                  if (func_ff) fc_ff <= fc_ff + FCW'(1);
                  frc_ff <= frc_ff + FRW'(1);
               end else begin
                  frc_ff <= FRW'(MAX_FRAMES + 1);
               end
            end else begin
               pos_ff <= addr_ff + AW'(1);
            end
         end
         if (cmd.report) begin
            pos_ff      <= '0;
            fc_ff       <= '0;
            frc_ff      <= '0;
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         smp_ff  <= req_data.sample;
         func_ff <= req_data.functional;
         last_ff <= req_data.last;
      end
      if (cmd.dims1) begin
         sdim_ff <= SDW'(xs) * SDW'(ys);
         sqr_ff  <= (2 * SAMPLE_W - 1)'(unsigned'(prod));
      end
      if (cmd.dims2) vdim_ff <= VDW'(sdim_ff) * VDW'(zs);
      if (cmd.rd) addr_ff <= rd_addr;
      if (cmd.sc_mul) begin
         a_ff <= DW'(fc_ff) * DW'(rd_sq_ff);
         b_ff <= DW'(mag) * DW'(mag);
      end
      if (cmd.sc_init) begin
         cbase_ff      <= '0;
         k_ff          <= '0;
         z_ff          <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         col_ff        <= '0;
         best_ff       <= '0;
         second_ff     <= '0;
         has_second_ff <= 1'b0;
         first_ff      <= 1'b1;
         bx_ff         <= '0;
         by_ff         <= '0;
      end
      if (cmd.sc_acc) begin
         col_ff <= col_sum[SCORE_W] ? '1 : col_sum[SCORE_W-1:0];
         k_ff   <= k_ff + AW'(sdim_ff);
         z_ff   <= z_ff + ZW'(1);
      end
      if (cmd.sc_col) begin
         if (first_ff) begin
            best_ff <= col_masked;
            bx_ff   <= x_ff;
            by_ff   <= y_ff;
         end else if (col_masked > best_ff) begin
            second_ff     <= best_ff;
            has_second_ff <= 1'b1;
            best_ff       <= col_masked;
            bx_ff         <= x_ff;
            by_ff         <= y_ff;
         end else if (!has_second_ff || col_masked > second_ff) begin
            second_ff     <= col_masked;
            has_second_ff <= 1'b1;
         end
         first_ff <= 1'b0;
         cbase_ff <= cbase_ff + AW'(1);
         k_ff     <= cbase_ff + AW'(1);
         z_ff     <= '0;
         col_ff   <= '0;
         if (x_ff == xs - XW'(1)) begin
            x_ff <= '0;
            y_ff <= y_ff + YW'(1);
         end else begin
            x_ff <= x_ff + XW'(1);
         end
      end
   end

   always_comb begin
      status.last     = last_ff;
      status.z_last   = (z_ff == zs - ZW'(1));
      status.col_last = (VDW'(cbase_ff) == VDW'(sdim_ff) - VDW'(1));
      status.clr_last = (clr_addr_ff == AW'(DEPTH - 1));
      priority if (pos_ff != '0) status.err = ERR_PARTIAL;
      else if (frc_ff > FRW'(MAX_FRAMES)) status.err = ERR_TOO_MANY;
      else if (fc_ff == '0) status.err = ERR_NO_FUNC;
      else status.err = ERR_NONE;
   end

   always_comb begin
      spike = ({1'b0, best_ff} > {second_ff, 1'b0}) &&
              (bx_ff != '0) && (bx_ff != xs - XW'(1)) &&
              (by_ff != '0) && (by_ff != ys - YW'(1));
      rsp_data            = '0;
      rsp_data.error_code = status.err;
      if (status.err == ERR_NONE) begin
         rsp_data.spike_found  = spike;
         rsp_data.peak_x       = DIM_W'(32'(bx_ff) + 1);
         rsp_data.peak_y       = DIM_W'(32'(by_ff) + 1);
         rsp_data.peak_score   = best_ff;
         rsp_data.second_score = second_ff;
      end
   end

endmodule

FILE: sv/temporal_variance_spike_locator_unit.sv
// Takes one voxel sample per start pulse (x fastest, then y, z, frame) and,
// on the sample marked last, scans all columns (not on an error) and puts
// one result word on rsp_data for a single cycle with rsp_valid; the
// receiver cannot stall it, so it must capture the word in that cycle. Each
// sample runs through DIM1, DIM2, READ and UPDATE before the next start
// (clamp products, then a read-modify-write of the voxel memories through
// one registered read port). The last sample adds a check, a scan of each
// column of the slice (per z: memory read, multiply, accumulate; then a
// column step), a report and a clearing pass over all MAX_X*MAX_Y*MAX_Z
// voxel entries, as after reset. busy stays high through scan and clearing.
module temporal_variance_spike_locator_unit #(
   parameter int MAX_X      = 64,
   parameter int MAX_Y      = 64,
   parameter int MAX_Z      = 16,
   parameter int MAX_FRAMES = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  tvsl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output tvsl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [tvsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tvsl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tvsl_pkg::*;

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_size        <= DIM_W'(64);
         cfg_ff.y_size        <= DIM_W'(64);
         cfg_ff.z_size        <= ZDIM_W'(16);
         cfg_ff.column_select <= '0;
         cfg_ff.row_select    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_X_SIZE:        cfg_ff.x_size        <= csr_wdata;
            CSR_Y_SIZE:        cfg_ff.y_size        <= csr_wdata;
            CSR_Z_SIZE:        cfg_ff.z_size        <= csr_wdata[ZDIM_W-1:0];
            CSR_COLUMN_SELECT: cfg_ff.column_select <= csr_wdata;
            CSR_ROW_SELECT:    cfg_ff.row_select    <= csr_wdata;
            default: ;
         endcase
      end
   end

   tvsl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tvsl_dp #(
      .MAX_X      (MAX_X),
      .MAX_Y      (MAX_Y),
      .MAX_Z      (MAX_Z),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = cmd.report;

   // memories are swept clean right after a result
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> busy && !rsp_valid)
      else $error("no clearing pass after result");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |->
         !rsp_data.spike_found && rsp_data.peak_score == '0 &&
         rsp_data.second_score == '0)
      else $error("error result carries data");

   a_peak_ordering: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == ERR_NONE |->
         rsp_data.peak_score >= rsp_data.second_score)
      else $error("runner-up above peak");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not make block busy");

endmodule
